// File: hw/rtl/ppc_pkg.sv
// Package: shared widths, types and register codes of the polygon plane clipper.
package ppc_pkg;

  localparam int COORD_W   = 32;
  localparam int NORM_W    = 18;
  localparam int DIST_W    = 52;
  localparam int DIV_W     = 53;
  localparam int T_W       = 17;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 50;
  localparam int CNT_W     = 10;
  localparam int VIDX_W    = 9;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [DIST_W-1:0]  dist_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_NX     = 3'd0,
    CFG_PLANE_NY     = 3'd1,
    CFG_PLANE_NZ     = 3'd2,
    CFG_PLANE_D      = 3'd3,
    CFG_VERTEX_COUNT = 3'd4,
    CFG_MAX_OUTPUT   = 3'd5
  } cfg_reg_t;

endpackage

// File: hw/rtl/ppc_if.sv
// Interfaces: vertex input, result output and configuration write channels.
interface ppc_vertex_if;
  logic        valid;
  logic        ready;
  logic [31:0] vertex_x;
  logic [31:0] vertex_y;
  logic [31:0] vertex_z;
  modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                  output ready);
endinterface

interface ppc_result_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [9:0]  produced_count;
  logic        last;
  modport source (output valid, output item_kind, output out_x, output out_y,
                  output out_z, output produced_count, output last, input ready);
  modport sink   (input valid, input item_kind, input out_x, input out_y,
                  input out_z, input produced_count, input last, output ready);
endinterface

interface ppc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/ppc_dist.sv
// Bit-serial signed distance: Horner over the normal bits, then the offset.
module ppc_dist (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ppc_pkg::vec3_t v,
  input  ppc_pkg::norm_t nx,
  input  ppc_pkg::norm_t ny,
  input  ppc_pkg::norm_t nz,
  input  ppc_pkg::coord_t d,
  output logic           done,
  output ppc_pkg::dist_t s
);
  import ppc_pkg::*;

  logic [NORM_W-1:0] bx, by, bz;
  logic [STEP_W-1:0] cnt;
  logic              run;
  logic signed [COORD_W+1:0] term;
  dist_t term_ext, acc_step, d_ext;

  always_comb begin
    term = (bx[NORM_W-1] ? {{2{v.x[COORD_W-1]}}, v.x} : '0)
         + (by[NORM_W-1] ? {{2{v.y[COORD_W-1]}}, v.y} : '0)
         + (bz[NORM_W-1] ? {{2{v.z[COORD_W-1]}}, v.z} : '0);
    term_ext = {{(DIST_W-COORD_W-2){term[COORD_W+1]}}, term};
    // sign bit of the normal carries negative weight
    if (cnt == '0) acc_step = -term_ext;
    else           acc_step = (s <<< 1) + term_ext;
    d_ext = {{(DIST_W-COORD_W-FRAC_BITS){d[COORD_W-1]}}, d, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        bx  <= nx;
        by  <= ny;
        bz  <= nz;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (cnt < STEP_W'(NORM_W)) begin
          s   <= acc_step;
          bx  <= bx << 1;
          by  <= by << 1;
          bz  <= bz << 1;
          cnt <= cnt + 1'b1;
        end else begin
          s    <= s + d_ext;
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/ppc_div.sv
// Restoring divider, one quotient bit a cycle, for the crossing fraction.
module ppc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ppc_pkg::DIV_W-1:0] num,
  input  logic [ppc_pkg::DIV_W-1:0] den,
  output logic                      done,
  output logic [ppc_pkg::T_W-1:0]   t
);
  import ppc_pkg::*;

  logic [DIV_W:0]       r, rs;
  logic [DIV_W-1:0]     dv;
  logic [FRAC_BITS-1:0] q;
  logic [STEP_W-1:0]    cnt;
  logic                 run, qbit;

  always_comb begin
    rs   = {r[DIV_W-1:0], 1'b0};
    qbit = (rs >= {1'b0, dv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num >= den) begin
          t    <= T_W'(1) << FRAC_BITS;   // far end on the plane: full step
          done <= 1'b1;
        end else begin
          r   <= {1'b0, num};
          dv  <= den;
          q   <= '0;
          cnt <= '0;
          run <= 1'b1;
        end
      end else if (run) begin
        r   <= qbit ? (rs - {1'b0, dv}) : rs;
        q   <= {q[FRAC_BITS-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(FRAC_BITS - 1)) begin
          t    <= {1'b0, q[FRAC_BITS-2:0], qbit};
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/ppc_lerp.sv
// Serial interpolation a + floor(t*(b-a)/2^16) on three lanes at once.
module ppc_lerp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [ppc_pkg::T_W-1:0] t,
  input  ppc_pkg::vec3_t          a,
  input  ppc_pkg::vec3_t          b,
  output logic                    done,
  output ppc_pkg::vec3_t          p
);
  import ppc_pkg::*;

  coord_t av [3];
  coord_t bv [3];
  coord_t pl [3];
  logic signed [COORD_W:0]  diff [3];
  logic signed [PROD_W-1:0] acc  [3];
  logic [T_W-1:0]    tb;
  logic [STEP_W-1:0] cnt;
  logic              run;

  assign av[0] = a.x;
  assign av[1] = a.y;
  assign av[2] = a.z;
  assign bv[0] = b.x;
  assign bv[1] = b.y;
  assign bv[2] = b.z;
  assign p = {pl[0], pl[1], pl[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        tb  <= t;
        cnt <= '0;
        run <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          diff[i] <= {bv[i][COORD_W-1], bv[i]} - {av[i][COORD_W-1], av[i]};
          acc[i]  <= '0;
        end
      end else if (run) begin
        if (cnt < STEP_W'(T_W)) begin
          for (int i = 0; i < 3; i++)
            acc[i] <= (acc[i] <<< 1)
                    + (tb[T_W-1] ? {{(PROD_W-COORD_W-1){diff[i][COORD_W]}}, diff[i]} : '0);
          tb  <= tb << 1;
          cnt <= cnt + 1'b1;
        end else begin
          // arithmetic shift is the floor; result wraps to 32 bits
          for (int i = 0; i < 3; i++)
            pl[i] <= av[i] + acc[i][COORD_W+FRAC_BITS-1:FRAC_BITS];
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/polygon_plane_clipper_top.sv
// Top level: polygon clipper against one plane, with sequencer and result register.
//
// One vertex item is taken at a time; ready is high only while the sequencer is
// idle. Each vertex waits on the bit-serial distance unit (one normal bit a cycle,
// then the offset). Every edge is then classified; an edge that crosses the plane
// goes through the restoring divider (which skips the division when the far end
// lies on the plane) and then the serial interpolator. Each emitted item waits
// until the result register is free. The last vertex also runs the closing edge
// and the done item after its own edge. A polygon with a vertex count of zero or
// above MAX_VERTICES gives one done item with count zero per vertex. The result
// register lets the next vertex enter while a finished item waits downstream.
module polygon_plane_clipper_top #(
  parameter int MAX_VERTICES = 256
) (
  input logic clk,
  input logic rst,
  ppc_vertex_if.sink   vertex,
  ppc_result_if.source result,
  ppc_cfg_if.sink      cfg
);
  import ppc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_EDGE, S_DIV, S_LERP, S_PUSHX, S_PUSHB, S_EDGE_END, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  norm_t            nx, ny, nz;
  coord_t           pd;
  logic [VIDX_W-1:0] vcount;
  logic [CNT_W-1:0]  maxo;

  // polygon state
  vec3_t cur, first, prev, ea, eb;
  dist_t cur_s, first_s, prev_s, ea_s, eb_s;
  logic [VIDX_W-1:0] vidx;
  logic [CNT_W-1:0]  emitted;
  logic edge_sel, need_b;

  // result register
  logic              res_valid, res_kind, res_last, res_load;
  coord_t            res_x, res_y, res_z;
  logic [CNT_W-1:0]  res_cnt;

  // serial units
  logic  dist_start, dist_done, div_start, div_done, lerp_start, lerp_done;
  dist_t dist_s;
  logic [T_W-1:0] t_frac;
  vec3_t cross_p;

  logic signed [DIV_W-1:0] sa_e, sb_e;
  logic [DIV_W-1:0] mag_a, mag_b, den;
  logic a_in, b_in, slot_free, can_push, is_last, empty_poly, in_acc;

  assign cfg.ready    = 1'b1;
  assign vertex.ready = (state == S_IDLE);
  assign in_acc       = vertex.valid && vertex.ready;

  assign result.valid          = res_valid;
  assign result.item_kind      = res_kind;
  assign result.out_x          = res_x;
  assign result.out_y          = res_y;
  assign result.out_z          = res_z;
  assign result.produced_count = res_cnt;
  assign result.last           = res_last;

  always_comb begin
    a_in  = !ea_s[DIST_W-1];
    b_in  = !eb_s[DIST_W-1];
    sa_e  = {ea_s[DIST_W-1], ea_s};
    sb_e  = {eb_s[DIST_W-1], eb_s};
    mag_a = sa_e[DIV_W-1] ? DIV_W'(-sa_e) : DIV_W'(sa_e);
    mag_b = sb_e[DIV_W-1] ? DIV_W'(-sb_e) : DIV_W'(sb_e);
    den   = mag_a + mag_b;
    slot_free  = !res_valid || result.ready;
    can_push   = (emitted < maxo);
    is_last    = ({1'b0, vidx} + 10'd1) >= {1'b0, vcount};
    empty_poly = (vcount == '0) || (32'(vcount) > 32'(MAX_VERTICES));
    dist_start = in_acc && !empty_poly;
    div_start  = (state == S_EDGE) && (a_in != b_in);
    lerp_start = (state == S_DIV) && div_done;
    // an item enters the result register this cycle
    res_load   = ((state inside {S_PUSHX, S_PUSHB}) && can_push && slot_free)
               || ((state == S_DONE) && slot_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nx     <= norm_t'(18'sd65536);
      ny     <= '0;
      nz     <= '0;
      pd     <= '0;
      vcount <= '0;
      maxo   <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_PLANE_NX:     nx     <= cfg.data[NORM_W-1:0];
        CFG_PLANE_NY:     ny     <= cfg.data[NORM_W-1:0];
        CFG_PLANE_NZ:     nz     <= cfg.data[NORM_W-1:0];
        CFG_PLANE_D:      pd     <= cfg.data;
        CFG_VERTEX_COUNT: vcount <= cfg.data[VIDX_W-1:0];
        CFG_MAX_OUTPUT:   maxo   <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  ppc_dist u_dist (
    .clk, .rst, .start(dist_start), .v(cur), .nx, .ny, .nz, .d(pd),
    .done(dist_done), .s(dist_s)
  );

  ppc_div u_div (
    .clk, .rst, .start(div_start), .num(mag_a), .den,
    .done(div_done), .t(t_frac)
  );

  ppc_lerp u_lerp (
    .clk, .rst, .start(lerp_start), .t(t_frac), .a(ea), .b(eb),
    .done(lerp_done), .p(cross_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      vidx      <= '0;
      emitted   <= '0;
      edge_sel  <= 1'b0;
      need_b    <= 1'b0;
      first     <= '0;
      first_s   <= '0;
      prev      <= '0;
      prev_s    <= '0;
    end else begin
      if (res_load)          res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cur <= {vertex.vertex_x, vertex.vertex_y, vertex.vertex_z};
            if (empty_poly) begin
              vidx    <= '0;
              emitted <= '0;
              first   <= '0;
              first_s <= '0;
              prev    <= '0;
              prev_s  <= '0;
              state   <= S_DONE;
            end else begin
              state <= S_DIST;
            end
          end
        end
        S_DIST: begin
          if (dist_done) begin
            cur_s    <= dist_s;
            prev     <= cur;
            prev_s   <= dist_s;
            edge_sel <= 1'b0;
            if (vidx == '0) begin
              first   <= cur;
              first_s <= dist_s;
              state   <= S_EDGE_END;
            end else begin
              ea    <= prev;
              ea_s  <= prev_s;
              eb    <= cur;
              eb_s  <= dist_s;
              state <= S_EDGE;
            end
          end
        end
        S_EDGE: begin
          need_b <= b_in;
          if (a_in && b_in)      state <= S_PUSHB;
          else if (a_in || b_in) state <= S_DIV;
          else                   state <= S_EDGE_END;
        end
        S_DIV:  if (div_done)  state <= S_LERP;
        S_LERP: if (lerp_done) state <= S_PUSHX;
        S_PUSHX, S_PUSHB: begin
          if (!can_push || slot_free) begin
            if (can_push) begin
              res_kind  <= 1'b0;
              res_last  <= 1'b0;
              res_x     <= (state == S_PUSHX) ? cross_p.x : eb.x;
              res_y     <= (state == S_PUSHX) ? cross_p.y : eb.y;
              res_z     <= (state == S_PUSHX) ? cross_p.z : eb.z;
              res_cnt   <= emitted + 1'b1;
              emitted   <= emitted + 1'b1;
            end
            if (state == S_PUSHX && need_b) state <= S_PUSHB;
            else                            state <= S_EDGE_END;
          end
        end
        S_EDGE_END: begin
          if (edge_sel) begin
            state <= S_DONE;
          end else if (is_last) begin
            // closing edge back to the first vertex
            edge_sel <= 1'b1;
            ea       <= cur;
            ea_s     <= cur_s;
            eb       <= first;
            eb_s     <= first_s;
            state    <= S_EDGE;
          end else begin
            vidx  <= vidx + 1'b1;
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            res_kind  <= 1'b1;
            res_last  <= 1'b1;
            res_x     <= '0;
            res_y     <= '0;
            res_z     <= '0;
            res_cnt   <= emitted;
            vidx      <= '0;
            emitted   <= '0;
            first     <= '0;
            first_s   <= '0;
            prev      <= '0;
            prev_s    <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a clipped vertex always carries a count of at least one
  a_vertex_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.item_kind |-> result.produced_count != '0)
    else $error("clipped vertex with zero count");

  // done items carry zero coordinates
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.last |-> result.out_x == '0 && result.out_y == '0
                                    && result.out_z == '0)
    else $error("done item with non-zero coordinates");

  // after a done item loads, the next polygon starts from vertex zero
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && slot_free |=> vidx == '0 && emitted == '0 && state == S_IDLE)
    else $error("state not cleared after done item");

endmodule

// File: verif/polygon_plane_clipper_top_tb.sv
// Testbench for the polygon plane clipper: directed and random polygons checked against a predictor.
`timescale 1ns / 1ps

module polygon_plane_clipper_top_tb;
  import ppc_pkg::*;

  localparam int MAX_VERTS   = 256;
  localparam int DRAIN_WAIT  = 150;
  localparam int STALL_LIMIT = 6000;  // cycles with no item moving on any channel
  localparam int ITEM_TARGET = 170;

  // one expected result item
  typedef struct {
    bit        kind;
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] z;
    bit [9:0]  count;
    bit        last;
  } clip_item_t;

  // Predicts the clipper and holds the clipped vertices still owed by the block.
  class clip_scoreboard;
    longint nx, ny, nz, d;
    int unsigned vcount, maxout;
    longint fx, fy, fz, fdist, px, py, pz, pdist;
    int unsigned vidx, emitted;
    clip_item_t owed[$];
    int errors;

    function new();
      nx = 65536; ny = 0; nz = 0; d = 0;
      vcount = 0; maxout = 0;
      errors = 0;
      clear_polygon();
    endfunction

    function void clear_polygon();
      fx = 0; fy = 0; fz = 0; fdist = 0;
      px = 0; py = 0; pz = 0; pdist = 0;
      vidx = 0; emitted = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, bit [31:0] val);
      case (idx)
        CFG_PLANE_NX:     nx = longint'($signed(val[17:0]));
        CFG_PLANE_NY:     ny = longint'($signed(val[17:0]));
        CFG_PLANE_NZ:     nz = longint'($signed(val[17:0]));
        CFG_PLANE_D:      d = longint'($signed(val));
        CFG_VERTEX_COUNT: vcount = val[8:0];
        CFG_MAX_OUTPUT:   maxout = val[9:0];
        default: ;
      endcase
    endfunction

    function void owe(bit kind, longint x, longint y, longint z, int unsigned cnt);
      clip_item_t it;
      it.kind = kind;
      it.x = x[31:0];
      it.y = y[31:0];
      it.z = z[31:0];
      it.count = cnt[9:0];
      it.last = kind;
      owed.insert(owed.size(), it);
    endfunction

    function void emit_vertex(longint x, longint y, longint z);
      if (emitted >= maxout) return;
      emitted++;
      owe(1'b0, x, y, z, emitted);
    endfunction

    // t = |sa| / (|sa| + |sb|) as Q1.16, restoring division, 65536 when sb is zero
    function longint cross_ratio(longint sa, longint sb);
      longint num, den, r, t;
      num = (sa < 0) ? -sa : sa;
      den = num + ((sb < 0) ? -sb : sb);
      t = 0;
      r = num;
      if (num >= den) return 65536;
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        t = t << 1;
        if (r >= den) begin
          r = r - den;
          t = t | 1;
        end
      end
      return t;
    endfunction

    function longint lerp(longint a, longint b, longint t);
      return a + ((t * (b - a)) >>> 16);
    endfunction

    function void clip_edge(longint ax, longint ay, longint az, longint sa,
                            longint bx, longint by, longint bz, longint sb);
      longint t;
      t = cross_ratio(sa, sb);
      if (sa >= 0 && sb >= 0) begin
        emit_vertex(bx, by, bz);
      end else if (sa >= 0) begin
        emit_vertex(lerp(ax, bx, t), lerp(ay, by, t), lerp(az, bz, t));
      end else if (sb >= 0) begin
        emit_vertex(lerp(ax, bx, t), lerp(ay, by, t), lerp(az, bz, t));
        emit_vertex(bx, by, bz);
      end
    endfunction

    function void note_vertex(bit [31:0] vx, bit [31:0] vy, bit [31:0] vz);
      longint x, y, z, s;
      x = longint'($signed(vx));
      y = longint'($signed(vy));
      z = longint'($signed(vz));
      if (vcount == 0 || vcount > MAX_VERTS) begin
        clear_polygon();
        owe(1'b1, 0, 0, 0, 0);
        return;
      end
      s = nx * x + ny * y + nz * z + d * 65536;
      if (vidx == 0) begin
        fx = x; fy = y; fz = z; fdist = s;
      end else begin
        clip_edge(px, py, pz, pdist, x, y, z, s);
      end
      px = x; py = y; pz = z; pdist = s;
      if (vidx + 1 >= vcount) begin
        clip_edge(x, y, z, s, fx, fy, fz, fdist);
        owe(1'b1, 0, 0, 0, emitted);
        clear_polygon();
      end else begin
        vidx++;
      end
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    task check_result(clip_item_t got);
      clip_item_t want;
      if (owed.size() == 0) begin
        report("unexpected item", got.kind, 0);
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind)   report("item_kind", got.kind, want.kind);
      if (got.x !== want.x)         report("out_x", got.x, want.x);
      if (got.y !== want.y)         report("out_y", got.y, want.y);
      if (got.z !== want.z)         report("out_z", got.z, want.z);
      if (got.count !== want.count) report("produced_count", got.count, want.count);
      if (got.last !== want.last)   report("last", got.last, want.last);
    endtask
  endclass

  logic clk;
  logic rst;

  ppc_vertex_if vin ();
  ppc_result_if rout ();
  ppc_cfg_if    cfg ();

  polygon_plane_clipper_top #(.MAX_VERTICES(MAX_VERTS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .vertex (vin.sink),
    .result (rout.source),
    .cfg    (cfg.sink)
  );

  clip_scoreboard sb;
  int burst_left;
  int sent;
  int idle_cycles;
  int ready_phase;
  int ready_mode;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: stall pattern is redrawn whenever ready_phase wraps; mode 0 never stalls.
  always @(posedge clk) begin
    clip_item_t got;
    if (rst) begin
      rout.ready <= 1'b0;
      ready_phase <= 0;
      ready_mode <= 0;
    end else begin
      if (rout.valid && rout.ready) begin
        got.kind = rout.item_kind;
        got.x = rout.out_x;
        got.y = rout.out_y;
        got.z = rout.out_z;
        got.count = rout.produced_count;
        got.last = rout.last;
        sb.check_result(got);
      end
      if (ready_phase == 149) begin
        ready_phase <= 0;
        ready_mode <= $urandom_range(0, 3);
      end else begin
        ready_phase <= ready_phase + 1;
      end
      case (ready_mode)
        0: rout.ready <= 1'b1;
        1: rout.ready <= ($urandom_range(0, 9) < 7);
        2: rout.ready <= (ready_phase % 5 != 0);
        default: rout.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: any accepted item on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (vin.valid && vin.ready) || (rout.valid && rout.ready)
        || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[polygon_plane_clipper_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drop vertex valid, let every owed item arrive, then let a vertex with no
  // result work its way out of the sequencer.
  task drain();
    vin.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    burst_left = 0;
  endtask

  task set_reg(cfg_reg_t idx, bit [31:0] val);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    sb.write_reg(idx, val);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender in bursts; valid is only lowered on a gap, never between two items of a burst.
  task send_vertex(bit [31:0] x, bit [31:0] y, bit [31:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        vin.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    vin.valid <= 1'b1;
    vin.vertex_x <= x;
    vin.vertex_y <= y;
    vin.vertex_z <= z;
    do @(posedge clk); while (!(vin.valid && vin.ready));
    sb.note_vertex(x, y, z);
    sent++;
  endtask

  function bit [31:0] q16(int whole);
    return whole <<< 16;
  endfunction

  // Random coordinate: mostly within ten units either side of the origin, else anything.
  function bit [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return $urandom_range(0, 20 << 16) - (10 << 16);
    endcase
  endfunction

  function bit [31:0] rand_norm();
    case ($urandom_range(0, 5))
      0: return 32'hfffe_0000;
      1: return 32'h0001_ffff;
      2: return 32'h0;
      default: return {{14{1'b0}}, 18'($urandom())} ^ 32'h0;
    endcase
  endfunction

  initial begin
    int nverts;
    sb = new();
    sent = 0;
    burst_left = 0;
    rst = 1'b1;
    vin.valid = 1'b0;
    vin.vertex_x = '0;
    vin.vertex_y = '0;
    vin.vertex_z = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_PLANE_NX;
    cfg.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty polygon out of reset: a zero-count done item per vertex.
    send_vertex(q16(1), q16(2), q16(3));
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0);

    // Single vertex: closing edge from the vertex to itself.
    set_reg(CFG_MAX_OUTPUT, 512);
    set_reg(CFG_VERTEX_COUNT, 1);
    send_vertex(q16(1), q16(-5), q16(7));
    send_vertex(q16(-1), q16(5), q16(7));

    // Triangles: crossing, wholly inside at the extremes, wholly outside.
    set_reg(CFG_VERTEX_COUNT, 3);
    set_reg(CFG_MAX_OUTPUT, 8);
    send_vertex(q16(-2), q16(0), q16(0));
    send_vertex(q16(3), q16(1), q16(0));
    send_vertex(q16(1), q16(-4), q16(2));
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_vertex(32'h0, 32'hffff_ffff, 32'h8000_0000);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
    send_vertex(32'h8000_0000, q16(4), q16(4));
    send_vertex(q16(-1), 32'h7fff_ffff, 32'h8000_0000);
    send_vertex(32'hffff_ffff, q16(1), q16(1));

    // Output full: a crossing triangle with room for two vertices, then none.
    set_reg(CFG_MAX_OUTPUT, 2);
    send_vertex(q16(-3), q16(1), q16(0));
    send_vertex(q16(4), q16(2), q16(1));
    send_vertex(q16(5), q16(-2), q16(3));
    set_reg(CFG_MAX_OUTPUT, 0);
    send_vertex(q16(1), q16(1), q16(1));
    send_vertex(q16(2), q16(1), q16(1));
    send_vertex(q16(3), q16(3), q16(1));

    // Extreme plane: most negative and most positive normal parts, offsets at both ends.
    set_reg(CFG_MAX_OUTPUT, 512);
    set_reg(CFG_PLANE_NX, 32'hfffe_0000);
    set_reg(CFG_PLANE_NY, 32'h0001_ffff);
    set_reg(CFG_PLANE_NZ, 32'hfffe_0000);
    set_reg(CFG_PLANE_D, 32'h8000_0000);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_vertex(q16(0), q16(0), q16(0));
    set_reg(CFG_PLANE_D, 32'h7fff_ffff);

    // Oversize count behaves as empty.
    set_reg(CFG_VERTEX_COUNT, 300);
    send_vertex(q16(2), q16(2), q16(2));

    // Count lowered mid polygon: third vertex becomes the last one.
    set_reg(CFG_PLANE_NX, 65536);
    set_reg(CFG_PLANE_NY, 0);
    set_reg(CFG_PLANE_NZ, 0);
    set_reg(CFG_PLANE_D, 0);
    set_reg(CFG_VERTEX_COUNT, 4);
    send_vertex(q16(-1), q16(0), q16(0));
    send_vertex(q16(2), q16(3), q16(0));
    set_reg(CFG_VERTEX_COUNT, 2);
    send_vertex(q16(1), q16(-3), q16(0));

    // Random polygons under random planes; most are well-formed and small.
    while (sent < ITEM_TARGET) begin
      set_reg(CFG_PLANE_NX, rand_norm());
      set_reg(CFG_PLANE_NY, rand_norm());
      set_reg(CFG_PLANE_NZ, rand_norm());
      case ($urandom_range(0, 4))
        0: set_reg(CFG_PLANE_D, $urandom());
        1: set_reg(CFG_PLANE_D, 32'h8000_0000);
        default: set_reg(CFG_PLANE_D, $urandom_range(0, 8 << 16) - (4 << 16));
      endcase
      case ($urandom_range(0, 5))
        0: set_reg(CFG_MAX_OUTPUT, $urandom_range(0, 4));
        1: set_reg(CFG_MAX_OUTPUT, 1023);
        default: set_reg(CFG_MAX_OUTPUT, 512);
      endcase
      case ($urandom_range(0, 9))
        0: nverts = 0;
        1: nverts = $urandom_range(257, 511);
        default: nverts = $urandom_range(1, 8);
      endcase
      set_reg(CFG_VERTEX_COUNT, nverts);
      if (nverts == 0 || nverts > MAX_VERTS) nverts = $urandom_range(1, 3);
      // one to three polygons back to back under one setting
      repeat ($urandom_range(1, 3)) begin
        for (int i = 0; i < nverts; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());
        if ($urandom_range(0, 5) == 0) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("[polygon_plane_clipper_top] OK");
    end else begin
      $display("[polygon_plane_clipper_top] ERROR");
    end
    $finish;
  end

endmodule
